>>> rtl/discrete_event_time_queue_macros.svh
// Assertion macros for the discrete event time queue.
`ifndef DISCRETE_EVENT_TIME_QUEUE_MACROS_SVH
`define DISCRETE_EVENT_TIME_QUEUE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off during reset.
`define DETQ_ASSERT_IMPLY(label, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_c)) \
        else $error("assertion failed: cond_a implies cond_c");

// Next-cycle implication, sampled on clk, off during reset.
`define DETQ_ASSERT_NEXT(label, cond_a, cond_c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_c)) \
        else $error("assertion failed: cond_a then cond_c");

`else

`define DETQ_ASSERT_IMPLY(label, cond_a, cond_c)
`define DETQ_ASSERT_NEXT(label, cond_a, cond_c)

`endif

`endif

>>> rtl/detq_pkg.sv
// Types and constants shared by the event queue modules.
package detq_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_PAST     = 3'd1,
        ST_BEYOND   = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_FULL     = 3'd4,
        ST_NONE     = 3'd5,
        ST_END      = 3'd6
    } status_t;

    // Input modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_DRAIN  = 2'd2;

    localparam logic [4:0]  MAX_TYPE       = 5'd17;
    localparam logic [63:0] END_TIME_RESET = 64'd600000000;

    // Control state machine
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [63:0] ins_time;
        logic [4:0]  ins_type;
    } cell_ctl_t;

endpackage

>>> rtl/detq_cell.sv
// One cell of the sorted event chain: holds one event, shifts on insert or pop.
module detq_cell
    import detq_pkg::*;
#(
    parameter int TAG_BITS = 16
)
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic [TAG_BITS-1:0] ins_tag,
    input  logic                occ,
    input  logic                left_gt,
    input  logic [63:0]         left_time,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic [4:0]          left_type,
    input  logic [63:0]         right_time,
    input  logic [TAG_BITS-1:0] right_tag,
    input  logic [4:0]          right_type,
    output logic                gt,
    output logic [63:0]         cur_time,
    output logic [TAG_BITS-1:0] cur_tag,
    output logic [4:0]          cur_type
);

    logic [63:0]         ev_time_reg, ev_time_next;
    logic [TAG_BITS-1:0] ev_tag_reg, ev_tag_next;
    logic [4:0]          ev_type_reg, ev_type_next;

    // Empty cells count as later than any new event; equal times stay put
    assign gt = !occ || (ev_time_reg > ctl.ins_time);

    // Next content: keep, take from the left / the new event, or take from the right
    always_comb
    begin
        ev_time_next = ev_time_reg;
        ev_tag_next  = ev_tag_reg;
        ev_type_next = ev_type_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        ev_time_next = left_time;
                        ev_tag_next  = left_tag;
                        ev_type_next = left_type;
                    end
                    else
                    begin
                        ev_time_next = ctl.ins_time;
                        ev_tag_next  = ins_tag;
                        ev_type_next = ctl.ins_type;
                    end
                end
            end
            CELL_POP:
            begin
                ev_time_next = right_time;
                ev_tag_next  = right_tag;
                ev_type_next = right_type;
            end
            default:
            begin
            end
        endcase
    end

    // Event payload
    always_ff @(posedge clk)
    begin
        ev_time_reg <= ev_time_next;
        ev_tag_reg  <= ev_tag_next;
        ev_type_reg <= ev_type_next;
    end

    assign cur_time = ev_time_reg;
    assign cur_tag  = ev_tag_reg;
    assign cur_type = ev_type_reg;

endmodule

>>> rtl/discrete_event_time_queue.sv
// Time-ordered event queue built as a chain of sorted cells, with control and output register.
//
//   channel  direction  handshake            words
//   in       input      in_valid / in_stall  mode, event_time, event_tag, event_type, time_limit
//   out      output     out_valid / out_stall status, out_time, out_tag, out_type, now_time,
//                                            queued, peak_queued, last
//   cfg      input      cfg_valid / cfg_ready cfg_data (end_time)
//
// Insert, pop or an empty drain is accepted in S_IDLE and carried out in S_EXEC, where a pop
// shifts the whole cell chain by one place and an insert shifts only the cells behind the new
// event. A drain gives one word per cycle after the accept while the output does not stall,
// one chain shift per popped event. Reset clears the count, the high-water mark and the current
// time; cell contents are not cleared, there is no clearing pass. A stalled output word holds in
// the output register; the execute step waits until that register is free.
module discrete_event_time_queue
    import detq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [63:0]         event_time,
    input  logic [TAG_BITS-1:0] event_tag,
    input  logic [4:0]          event_type,
    input  logic [63:0]         time_limit,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [63:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [63:0]         out_time,
    output logic [TAG_BITS-1:0] out_tag,
    output logic [4:0]          out_type,
    output logic [63:0]         now_time,
    output logic [6:0]          queued,
    output logic [6:0]          peak_queued,
    output logic                last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [1:0]          mode_reg;
    logic [63:0]         etime_reg;
    logic [TAG_BITS-1:0] etag_reg;
    logic [4:0]          etype_reg;
    logic [63:0]         limit_reg;
    logic [63:0]         end_time_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    peak_reg, peak_next;
    logic [63:0]         cur_reg, cur_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg;
    logic [63:0]         out_time_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [4:0]          out_type_reg;
    logic [63:0]         now_reg;
    logic [CNT_W-1:0]    queued_reg;
    logic [CNT_W-1:0]    peak_out_reg;
    logic                last_reg;

    logic                load_out;
    status_t             o_status;
    logic                o_event;
    logic                o_last;

    logic                in_fire;
    logic                out_free;
    cell_ctl_t           ctl;
    logic [CNT_W-1:0]    count_inc;
    logic                head_ok;
    logic                next_ok;

    logic [QUEUE_DEPTH-1:0] occ;
    logic [QUEUE_DEPTH-1:0] c_gt;
    logic [63:0]            c_time [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    c_tag  [QUEUE_DEPTH];
    logic [4:0]             c_type [QUEUE_DEPTH];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_inc = count_reg + CNT_W'(1);

    // Occupancy of each cell from the fill count
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            occ[i] = CNT_W'(i) < count_reg;
        end
    end

    // Cell chain
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic                l_gt;
        logic [63:0]         l_time, r_time;
        logic [TAG_BITS-1:0] l_tag, r_tag;
        logic [4:0]          l_type, r_type;

        if (g == 0)
        begin : g_first
            assign l_gt   = 1'b0;
            assign l_time = '0;
            assign l_tag  = '0;
            assign l_type = '0;
        end
        else
        begin : g_mid
            assign l_gt   = c_gt[g-1];
            assign l_time = c_time[g-1];
            assign l_tag  = c_tag[g-1];
            assign l_type = c_type[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_time = '0;
            assign r_tag  = '0;
            assign r_type = '0;
        end
        else
        begin : g_body
            assign r_time = c_time[g+1];
            assign r_tag  = c_tag[g+1];
            assign r_type = c_type[g+1];
        end

        detq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .ins_tag    (etag_reg),
            .occ        (occ[g]),
            .left_gt    (l_gt),
            .left_time  (l_time),
            .left_tag   (l_tag),
            .left_type  (l_type),
            .right_time (r_time),
            .right_tag  (r_tag),
            .right_type (r_type),
            .gt         (c_gt[g]),
            .cur_time   (c_time[g]),
            .cur_tag    (c_tag[g]),
            .cur_type   (c_type[g])
        );
    end

    // Drain: head qualifies, and whether the one behind it will too
    assign head_ok = (count_reg != '0) && (c_time[0] <= limit_reg);
    assign next_ok = (count_reg > CNT_W'(1)) && (c_time[1] <= limit_reg);

    // Control: next state, chain operation, counters and output word
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        peak_next    = peak_reg;
        cur_next     = cur_reg;
        ctl.op       = CELL_HOLD;
        ctl.ins_time = etime_reg;
        ctl.ins_type = etype_reg;
        load_out     = 1'b0;
        o_status     = ST_NONE;
        o_event      = 1'b0;
        o_last       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    case (mode_reg)
                        MODE_INSERT:
                        begin
                            if (etime_reg < cur_reg)
                            begin
                                o_status = ST_PAST;
                            end
                            else if (etime_reg > end_time_reg)
                            begin
                                o_status = ST_BEYOND;
                            end
                            else if (etype_reg > MAX_TYPE)
                            begin
                                o_status = ST_BAD_TYPE;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                o_status = ST_FULL;
                            end
                            else
                            begin
                                o_status   = ST_OK;
                                ctl.op     = CELL_INSERT;
                                count_next = count_inc;
                                if (count_inc > peak_reg)
                                begin
                                    peak_next = count_inc;
                                end
                            end
                        end
                        MODE_POP:
                        begin
                            if (cur_reg >= end_time_reg)
                            begin
                                o_status = ST_END;
                            end
                            else if (count_reg == '0)
                            begin
                                o_status = ST_NONE;
                            end
                            else
                            begin
                                o_status   = ST_OK;
                                o_event    = 1'b1;
                                ctl.op     = CELL_POP;
                                count_next = count_reg - CNT_W'(1);
                                cur_next   = c_time[0];
                            end
                        end
                        MODE_DRAIN:
                        begin
                            if (head_ok)
                            begin
                                o_status   = ST_OK;
                                o_event    = 1'b1;
                                o_last     = !next_ok;
                                ctl.op     = CELL_POP;
                                count_next = count_reg - CNT_W'(1);
                                // last popped time never exceeds the limit
                                cur_next   = next_ok ? c_time[0] : limit_reg;
                                if (next_ok)
                                begin
                                    state_next = S_EXEC;
                                end
                            end
                            else
                            begin
                                o_status = ST_NONE;
                                if (limit_reg > cur_reg)
                                begin
                                    cur_next = limit_reg;
                                end
                            end
                        end
                        default:
                        begin
                            o_status = ST_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once taken
    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            peak_reg      <= '0;
            cur_reg       <= '0;
            end_time_reg  <= END_TIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                end_time_reg <= cfg_data;
            end
        end
    end

    // Captured input word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            etime_reg <= event_time;
            etag_reg  <= event_tag;
            etype_reg <= event_type;
            limit_reg <= time_limit;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg   <= o_status;
            out_time_reg <= o_event ? c_time[0] : '0;
            out_tag_reg  <= o_event ? c_tag[0] : '0;
            out_type_reg <= o_event ? c_type[0] : '0;
            now_reg      <= cur_next;
            queued_reg   <= count_next;
            peak_out_reg <= peak_next;
            last_reg     <= o_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_time    = out_time_reg;
    assign out_tag     = out_tag_reg;
    assign out_type    = out_type_reg;
    assign now_time    = now_reg;
    assign queued      = 7'(queued_reg);
    assign peak_queued = 7'(peak_out_reg);
    assign last        = last_reg;

    // Checks
    `include "discrete_event_time_queue_macros.svh"

    `DETQ_ASSERT_IMPLY(a_count_le_peak, 1'b1, count_reg <= peak_reg)
    `DETQ_ASSERT_NEXT(a_accept_exec, in_fire, state_reg == S_EXEC)
    `DETQ_ASSERT_NEXT(a_peak_monotonic, 1'b1, peak_reg >= $past(peak_reg))
    `DETQ_ASSERT_NEXT(a_time_monotonic, 1'b1, cur_reg >= $past(cur_reg))

endmodule
